// ----- rtl/core/per_source_count_aggregator_defines.svh -----
// Assertion macros shared by the aggregator RTL.
`ifndef PER_SOURCE_COUNT_AGGREGATOR_DEFINES_SVH
`define PER_SOURCE_COUNT_AGGREGATOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PSCA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check an implication in the same cycle.
`define PSCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define PSCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/psca_pkg.sv -----
// Shared types and constants for the per-source count aggregator.
package psca_pkg;

    localparam int OPCODE_W = 2;
    localparam int MAC_W    = 48;
    localparam int COUNT_W  = 24;
    localparam int THR_W    = 16;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int DELTA_W  = 25;
    localparam int SUM_W    = 32;
    localparam int USED_W   = 5;
    localparam int ALU_W    = 34;

    localparam logic [OPCODE_W-1:0] OP_REPORT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_MASTER = 2'd3;

    localparam logic signed [ALU_W-1:0] SUM_MAX = 34'sh0_FFFF_FFFF;

    typedef struct packed {
        logic sub;
        logic clamp;
    } alu_op_t;

    typedef struct packed {
        logic key_we;
        logic cnt_we;
    } tbl_wr_t;

endpackage

// ----- rtl/core/psca_alu.sv -----
// Shared add/subtract unit with optional clamp to the unsigned 32-bit range.
module psca_alu (
    input  psca_pkg::alu_op_t                  op,
    input  logic signed [psca_pkg::ALU_W-1:0]  a,
    input  logic signed [psca_pkg::ALU_W-1:0]  b,
    output logic signed [psca_pkg::ALU_W-1:0]  y
);
    import psca_pkg::*;

    logic signed [ALU_W-1:0] raw;

    always_comb
    begin
        raw = op.sub ? (a - b) : (a + b);
        y   = raw;
        if (op.clamp)
        begin
            if (raw < 0)
            begin
                y = '0;
            end
            else if (raw > SUM_MAX)
            begin
                y = SUM_MAX;
            end
        end
    end

endmodule

// ----- rtl/core/psca_table.sv -----
// Slot table memories: address with threshold, and stored count.
module psca_table #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                              clk,
    input  psca_pkg::tbl_wr_t                 wr,
    input  logic [$clog2(SLOT_COUNT)-1:0]     wr_addr,
    input  logic [psca_pkg::MAC_W-1:0]        wr_mac,
    input  logic [psca_pkg::THR_W-1:0]        wr_thr,
    input  logic [psca_pkg::COUNT_W-1:0]      wr_cnt,
    input  logic [$clog2(SLOT_COUNT)-1:0]     rd_addr,
    output logic [psca_pkg::MAC_W-1:0]        rd_mac,
    output logic [psca_pkg::THR_W-1:0]        rd_thr,
    output logic [psca_pkg::COUNT_W-1:0]      rd_cnt
);
    import psca_pkg::*;

    logic [MAC_W+THR_W-1:0] key_mem [SLOT_COUNT];
    logic [COUNT_W-1:0]     cnt_mem [SLOT_COUNT];
    logic [MAC_W+THR_W-1:0] key_rdata_reg;
    logic [COUNT_W-1:0]     cnt_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= {wr_mac, wr_thr};
        end
        key_rdata_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt_we)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        cnt_rdata_reg <= cnt_mem[rd_addr];
    end

    assign rd_mac = key_rdata_reg[MAC_W+THR_W-1:THR_W];
    assign rd_thr = key_rdata_reg[THR_W-1:0];
    assign rd_cnt = cnt_rdata_reg;

endmodule

// ----- rtl/core/per_source_count_aggregator.sv -----
// Top level: sequencer, sums and result register of the per-source count aggregator.
//
// Channel  Dir  Handshake              Word
// in       in   in_valid / in_ready    opcode, source_mac, reported_count, ...
// out      out  out_valid / out_ready  status, slot, is_new, count_delta, ...
// cfg      in   cfg_we                 cfg_wdata (master mode)
//
// A report scans the used slots up to a match, or all of them for a new address,
// then reads the count, forms the delta and updates both sums; on a full table it
// ends after the scan. A clear walks every slot; a read fetches the entry.
// The address scan reads one slot a cycle, the clear writes one count a cycle.
// One word in flight; the next word is taken while a result waits in the
// output register, and a waiting result holds the sequencer in its last step.
`include "per_source_count_aggregator_defines.svh"

module per_source_count_aggregator #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [psca_pkg::OPCODE_W-1:0]      opcode,
    input  logic [psca_pkg::MAC_W-1:0]         source_mac,
    input  logic [psca_pkg::COUNT_W-1:0]       reported_count,
    input  logic [psca_pkg::THR_W-1:0]         reported_threshold,
    input  logic [psca_pkg::INDEX_W-1:0]       entry_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [psca_pkg::STATUS_W-1:0]      status,
    output logic [psca_pkg::SLOT_W-1:0]        slot,
    output logic                               is_new,
    output logic signed [psca_pkg::DELTA_W-1:0] count_delta,
    output logic [psca_pkg::SUM_W-1:0]         total_count,
    output logic [psca_pkg::SUM_W-1:0]         present_count,
    output logic [psca_pkg::USED_W-1:0]        slots_used,
    output logic [psca_pkg::MAC_W-1:0]         entry_mac,
    output logic [psca_pkg::COUNT_W-1:0]       entry_count,
    output logic [psca_pkg::THR_W-1:0]         entry_threshold,
    output logic                               entry_valid
);
    import psca_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = CNT_W + INDEX_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_CNT_RD   = 4'd3;
    localparam logic [3:0] S_DELTA    = 4'd4;
    localparam logic [3:0] S_TOTAL    = 4'd5;
    localparam logic [3:0] S_PRESENT  = 4'd6;
    localparam logic [3:0] S_CLEAR    = 4'd7;
    localparam logic [3:0] S_ENTRY_RD = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic                     master_reg;
    logic [CNT_W-1:0]         used_reg;
    logic [SUM_W-1:0]         total_reg;
    logic [SUM_W-1:0]         present_reg;
    logic                     out_valid_reg;

    logic [OPCODE_W-1:0]      op_reg;
    logic [MAC_W-1:0]         mac_reg;
    logic [COUNT_W-1:0]       rcount_reg;
    logic [THR_W-1:0]         rthr_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]         scan_idx_reg;
    logic                     check_valid_reg;
    logic [IDX_W-1:0]         check_idx_reg;
    logic [IDX_W-1:0]         found_reg;
    logic                     is_new_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic                     entry_ok_reg;

    logic [STATUS_W-1:0]      out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic                     out_is_new_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;
    logic [SUM_W-1:0]         out_total_reg;
    logic [SUM_W-1:0]         out_present_reg;
    logic [USED_W-1:0]        out_used_reg;
    logic [MAC_W-1:0]         out_mac_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic [THR_W-1:0]         out_thr_reg;
    logic                     out_entry_valid_reg;

    logic                     issue;
    logic                     hit;
    logic                     scan_end;
    logic                     table_full;
    logic                     idx_in_range;
    logic                     clr_last;
    logic                     out_free;

    tbl_wr_t                  tbl_wr;
    logic [IDX_W-1:0]         tbl_wr_addr;
    logic [COUNT_W-1:0]       tbl_wr_cnt;
    logic [IDX_W-1:0]         tbl_rd_addr;
    logic [MAC_W-1:0]         tbl_rd_mac;
    logic [THR_W-1:0]         tbl_rd_thr;
    logic [COUNT_W-1:0]       tbl_rd_cnt;

    alu_op_t                  alu_op;
    logic signed [ALU_W-1:0]  alu_a;
    logic signed [ALU_W-1:0]  alu_b;
    logic signed [ALU_W-1:0]  alu_y;

    psca_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .wr_mac  (mac_reg),
        .wr_thr  (rthr_reg),
        .wr_cnt  (tbl_wr_cnt),
        .rd_addr (tbl_rd_addr),
        .rd_mac  (tbl_rd_mac),
        .rd_thr  (tbl_rd_thr),
        .rd_cnt  (tbl_rd_cnt)
    );

    psca_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign issue        = (scan_idx_reg < used_reg);
    assign hit          = check_valid_reg && (tbl_rd_mac == mac_reg);
    assign scan_end     = !issue && !check_valid_reg;
    assign table_full   = (used_reg == CNT_W'(SLOT_COUNT));
    assign idx_in_range = (CMP_W'(idx_reg) < CMP_W'(used_reg));
    assign clr_last     = (scan_idx_reg == CNT_W'(SLOT_COUNT - 1));
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_REPORT: state_next = master_reg ? S_SCAN : S_DONE;
                    OP_CLEAR:  state_next = S_CLEAR;
                    OP_READ:   state_next = idx_in_range ? S_ENTRY_RD : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_CNT_RD;
                end
                else if (scan_end)
                begin
                    state_next = table_full ? S_DONE : S_CNT_RD;
                end
            end
            S_CNT_RD:   state_next = S_DELTA;
            S_DELTA:    state_next = S_TOTAL;
            S_TOTAL:    state_next = S_PRESENT;
            S_PRESENT:  state_next = S_DONE;
            S_CLEAR:    state_next = clr_last ? S_DONE : S_CLEAR;
            S_ENTRY_RD: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        tbl_wr      = '0;
        tbl_wr_addr = found_reg;
        tbl_wr_cnt  = rcount_reg;
        if (state_reg == S_DELTA)
        begin
            tbl_wr.key_we = 1'b1;
            tbl_wr.cnt_we = 1'b1;
        end
        else if (state_reg == S_CLEAR)
        begin
            tbl_wr.cnt_we = 1'b1;
            tbl_wr_addr   = scan_idx_reg[IDX_W-1:0];
            tbl_wr_cnt    = '0;
        end
    end

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            tbl_rd_addr = scan_idx_reg[IDX_W-1:0];
        end
        else if (state_reg == S_CNT_RD)
        begin
            tbl_rd_addr = found_reg;
        end
        else
        begin
            tbl_rd_addr = IDX_W'(idx_reg);
        end
    end

    always_comb
    begin
        alu_op = '0;
        alu_a  = '0;
        alu_b  = '0;
        if (state_reg == S_DELTA)
        begin
            alu_op.sub = 1'b1;
            alu_a      = ALU_W'(rcount_reg);
            alu_b      = is_new_reg ? '0 : ALU_W'(tbl_rd_cnt);
        end
        else if (state_reg == S_TOTAL)
        begin
            alu_op.clamp = 1'b1;
            alu_a        = ALU_W'(total_reg);
            alu_b        = ALU_W'(delta_reg);
        end
        else if (state_reg == S_PRESENT)
        begin
            alu_op.clamp = 1'b1;
            alu_a        = ALU_W'(present_reg);
            alu_b        = ALU_W'(delta_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            master_reg    <= 1'b1;
            used_reg      <= '0;
            total_reg     <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                master_reg <= cfg_wdata;
            end
            if (state_reg == S_SCAN && !hit && scan_end && !table_full)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (state_reg == S_TOTAL)
            begin
                total_reg <= alu_y[SUM_W-1:0];
            end
            if (state_reg == S_PRESENT)
            begin
                present_reg <= alu_y[SUM_W-1:0];
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg     <= opcode;
                    mac_reg    <= source_mac;
                    rcount_reg <= reported_count;
                    rthr_reg   <= reported_threshold;
                    idx_reg    <= entry_index;
                end
            end
            S_DECODE:
            begin
                scan_idx_reg    <= '0;
                check_valid_reg <= 1'b0;
                check_idx_reg   <= '0;
                found_reg       <= '0;
                is_new_reg      <= 1'b0;
                delta_reg       <= '0;
                entry_ok_reg    <= (op_reg == OP_READ) && idx_in_range;
                if (op_reg == OP_REPORT && !master_reg)
                begin
                    res_status_reg <= ST_NOT_MASTER;
                end
                else if (op_reg == OP_READ && !idx_in_range)
                begin
                    res_status_reg <= ST_RANGE;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    found_reg <= check_idx_reg;
                end
                else if (scan_end)
                begin
                    if (table_full)
                    begin
                        res_status_reg <= ST_FULL;
                    end
                    else
                    begin
                        found_reg  <= used_reg[IDX_W-1:0];
                        is_new_reg <= 1'b1;
                    end
                end
                else
                begin
                    check_valid_reg <= issue;
                    check_idx_reg   <= scan_idx_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
            end
            S_DELTA:
            begin
                delta_reg <= alu_y[DELTA_W-1:0];
            end
            S_CLEAR:
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg      <= res_status_reg;
                    out_slot_reg        <= SLOT_W'(found_reg);
                    out_is_new_reg      <= is_new_reg;
                    out_delta_reg       <= delta_reg;
                    out_total_reg       <= total_reg;
                    out_present_reg     <= present_reg;
                    out_used_reg        <= USED_W'(used_reg);
                    out_mac_reg         <= entry_ok_reg ? tbl_rd_mac : '0;
                    out_count_reg       <= entry_ok_reg ? tbl_rd_cnt : '0;
                    out_thr_reg         <= entry_ok_reg ? tbl_rd_thr : '0;
                    out_entry_valid_reg <= entry_ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign slot            = out_slot_reg;
    assign is_new          = out_is_new_reg;
    assign count_delta     = out_delta_reg;
    assign total_count     = out_total_reg;
    assign present_count   = out_present_reg;
    assign slots_used      = out_used_reg;
    assign entry_mac       = out_mac_reg;
    assign entry_count     = out_count_reg;
    assign entry_threshold = out_thr_reg;
    assign entry_valid     = out_entry_valid_reg;

    `PSCA_ASSERT_ALWAYS(a_used_bound, used_reg <= CNT_W'(SLOT_COUNT), "slot count past table size")
    `PSCA_ASSERT_SAME(a_used_step, !$stable(used_reg), used_reg == CNT_W'($past(used_reg) + 1'b1), "slot count moved by other than one")
    `PSCA_ASSERT_NEXT(a_total_hold, state_reg != S_TOTAL, $stable(total_reg), "total changed outside its update step")
    `PSCA_ASSERT_SAME(a_hit_in_use, state_reg == S_SCAN && check_valid_reg, CNT_W'(check_idx_reg) < used_reg, "scan compared an unallocated slot")

endmodule
